// File: src/atnsl_pkg.sv
// Package for the arctan large-argument series block.
// Holds widths, the pi/2 constant and the sequencer state type; no dependencies.
`default_nettype none
package atnsl_pkg;
  localparam int XW    = 24;
  localparam int CNTW  = 11;
  localparam int TOLW  = 31;
  localparam int SUMW  = 31;
  localparam int TERMW = 32;
  localparam int FRAC  = 30;
  localparam int NW    = FRAC + 17;  // dividend: 2^(FRAC+16), a previous quotient, or a power or quotient shifted up 16
  localparam int DW    = XW;         // divisor: x or 2k-1
  localparam int ACCW  = 34;         // signed accumulator
  localparam logic [SUMW-1:0] HALF_PI = 31'd1686629713;
  localparam logic [XW-1:0]   ONE_Q16 = 24'd65536;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RECIP, ST_TERM, ST_POW1, ST_POW2, ST_DONE
  } state_t;
endpackage
`default_nettype wire

// File: src/atnsl_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on atnsl_pkg for widths.
`default_nettype none
module atnsl_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [atnsl_pkg::NW-1:0] num,
  input  wire logic [atnsl_pkg::DW-1:0] den,
  output logic                          busy,
  output logic                          done,
  output logic [atnsl_pkg::NW-1:0]      quo
);
  import atnsl_pkg::*;
  logic [NW-1:0] n;
  logic [DW:0]   rem;
  logic [DW-1:0] d;
  logic [5:0]    cnt;
  logic [DW:0]   trial;
  logic [DW:0]   sh;

  assign sh    = {rem[DW-1:0], n[NW-1]};
  assign trial = sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(NW);
        n    <= num;
        d    <= den;
        rem  <= '0;
      end else if (busy) begin
        n <= {n[NW-2:0], ~trial[DW]};
        rem <= trial[DW] ? sh : trial;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = n;
endmodule
`default_nettype wire

// File: src/arctan_series_large_argument.sv
// Arctangent for x >= 1 by its asymptotic series, one word at a time.
// One shared 47-bit serial divider forms 1/x, every power step (two divides by x)
// and every term (divide by 2k-1), one divide after another.
// The input is not ready until the result word has been taken.
`default_nettype none
module arctan_series_large_argument #(
  parameter int MAX_TERMS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // x_value[23:0], term_count[34:24], tolerance[65:35]
  input  wire logic        s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // sum[30:0], last_term[62:31], terms_used[73:63]
  output logic             m_tuser    // capped
);
  import atnsl_pkg::*;
  localparam int KW = $clog2(MAX_TERMS + 1) + 1;

  state_t state, state_next;
  logic             precise;
  logic [XW-1:0]    x;
  logic [KW-1:0]    limit, k;
  logic [TOLW-1:0]  tol;
  logic [NW-1:0]    pw;
  logic signed [ACCW-1:0] acc;
  logic signed [TERMW-1:0] term;
  logic             capped;
  logic             dstart, dbusy, ddone;
  logic [NW-1:0]    dnum, dquo;
  logic [DW-1:0]    dden;
  logic [XW-1:0]    xin;
  logic [CNTW-1:0]  nin;
  logic [KW-1:0]    nsat;
  logic             stop;

  atnsl_div u_div (.clk, .rst, .start(dstart), .num(dnum), .den(dden),
                   .busy(dbusy), .done(ddone), .quo(dquo));

  assign xin  = (s_tdata[23:0] < ONE_Q16) ? ONE_Q16 : s_tdata[23:0];
  assign nin  = (s_tdata[34:24] == '0) ? CNTW'(1) : s_tdata[34:24];
  assign nsat = (KW'(nin) > KW'(MAX_TERMS)) ? KW'(MAX_TERMS) : KW'(nin);
  assign stop = (precise && (dquo <= NW'(tol))) || (k == limit);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_RECIP;
      ST_RECIP: if (ddone) state_next = ST_TERM;
      ST_TERM:  if (ddone) state_next = stop ? ST_DONE : ST_POW1;
      ST_POW1:  if (ddone) state_next = ST_POW2;
      ST_POW2:  if (ddone) state_next = ST_TERM;
      ST_DONE:  if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dstart = 1'b0;
    dnum   = {pw[NW-17:0], 16'd0};
    dden   = DW'(x);
    unique case (state)
      ST_IDLE:  begin
        dstart = s_tvalid;
        dnum   = NW'(1) << (FRAC + 16);
        dden   = DW'(xin);
      end
      ST_RECIP: begin
        dstart = ddone;
        dnum   = dquo;
        dden   = DW'(1);
      end
      ST_POW2: begin
        // k steps up at this edge, so the next term divides by 2k+1
        dstart = ddone;
        dnum   = dquo;
        dden   = DW'({k, 1'b1});
      end
      ST_TERM:  dstart = ddone && !stop;
      ST_POW1:  begin
        dstart = ddone;
        dnum   = {dquo[NW-17:0], 16'd0};
      end
      default:  dstart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    unique case (state)
      ST_IDLE: if (s_tvalid) begin
        precise <= s_tuser;
        x       <= xin;
        limit   <= s_tuser ? KW'(MAX_TERMS) : nsat;
        tol     <= s_tdata[65:35];
        k       <= KW'(1);
        acc     <= ACCW'(HALF_PI);
        capped  <= 1'b0;
      end
      ST_RECIP: if (ddone) pw <= dquo;
      ST_TERM: if (ddone) begin
        term <= k[0] ? -TERMW'(dquo) : TERMW'(dquo);
        acc  <= k[0] ? acc - ACCW'(dquo) : acc + ACCW'(dquo);
        capped <= precise && (dquo > NW'(tol)) && (k == limit);
      end
      ST_POW2: if (ddone) begin
        pw <= dquo;
        k  <= k + KW'(1);
      end
      default: ;
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_DONE);
  assign m_tdata  = {6'd0, CNTW'(k), term, acc[ACCW-1] ? SUMW'(0) : acc[SUMW-1:0]};
  assign m_tuser  = capped;

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !dbusy) else $error("divider busy at result");
  a_k: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TERM) |-> (k != '0) && (k <= limit)) else $error("term index range");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("ready while result pending");
endmodule
`default_nettype wire
